FILE: hw/rtl/npts_pkg.sv
// Shared types and constants of the nearest point table search block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
package npts_pkg;

  localparam int unsigned CoordW   = 21;
  localparam int unsigned DistW    = 22;
  localparam int unsigned IdxOutW  = 9;
  localparam int unsigned QuotW    = 15;
  localparam int unsigned ProdW    = 43;
  localparam int unsigned RecipShift = 28;
  // ceil(2^28 / 100): exact truncating divide by 100 for magnitudes below 2^21
  localparam logic [21:0] Recip100  = 22'd2684355;
  localparam logic [DistW-1:0] ThrReset = 22'd50000;

  // APB byte address of the near threshold register.
  localparam logic [1:0] ThrAddr = 2'd0;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_NEAREST = 2'd2,
    CMD_DIRECT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CoordW-1:0] coord_lat;
    logic [CoordW-1:0] coord_lon;
    logic [1:0]        direction;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [IdxOutW-1:0] entry_index;
    logic [DistW-1:0]   best_distance;
    logic               table_full;
  } res_t;

  typedef struct packed {
    logic [CoordW-1:0] lat;
    logic [CoordW-1:0] lon;
  } point_t;

  // Marks one table entry moving down the scan pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic             elig;
    logic [DistW-1:0] metric;
  } met_t;

endpackage

FILE: hw/rtl/npts_store.sv
// Point table memory: one write port, one read port with registered data.
// Depends on npts_pkg for the point type.
`timescale 1ns / 1ps
module npts_store #(
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  npts_pkg::point_t         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output npts_pkg::point_t         rdata_o
);

  npts_pkg::point_t mem_q [Depth];
  npts_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/npts_metric.sv
// Shared distance unit: two pipeline stages that turn one table entry into
// a ranking metric for either query kind. Depends on npts_pkg.
`timescale 1ns / 1ps
module npts_metric (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  npts_pkg::tag_t            tag_i,
  input  npts_pkg::point_t          pt_i,
  input  logic [npts_pkg::CoordW-1:0] q_lat_i,
  input  logic [npts_pkg::CoordW-1:0] q_lon_i,
  input  logic [1:0]                dir_i,
  input  logic                      direct_i,
  output npts_pkg::met_t            met_o
);

  localparam int unsigned CW = npts_pkg::CoordW;
  localparam int unsigned QW = npts_pkg::QuotW;
  localparam int unsigned DW = npts_pkg::DistW;
  localparam int unsigned PW = npts_pkg::ProdW;

  logic signed [CW:0] dlat, dlon;
  logic [CW:0]        mlat, mlon;
  logic [PW-1:0]      prod_lat, prod_lon;

  npts_pkg::tag_t s1_tag_q, s2_tag_q;
  logic [CW-1:0]  a_lat_q, a_lon_q;
  logic           n_lat_q, n_lon_q, n2_lat_q, n2_lon_q;
  logic [QW-1:0]  qy_q, qx_q;
  logic [DW-1:0]  sum_q;

  logic [QW-1:0]  ahead, lateral;
  logic           ahead_pos;

  // Stage 1: entry minus query point, split into sign and magnitude.
  assign dlat = $signed({pt_i.lat[CW-1], pt_i.lat}) - $signed({q_lat_i[CW-1], q_lat_i});
  assign dlon = $signed({pt_i.lon[CW-1], pt_i.lon}) - $signed({q_lon_i[CW-1], q_lon_i});
  assign mlat = dlat[CW] ? (CW+1)'(-dlat) : (CW+1)'(dlat);
  assign mlon = dlon[CW] ? (CW+1)'(-dlon) : (CW+1)'(dlon);

  // Stage 2: divide magnitudes by 100 via reciprocal multiply.
  assign prod_lat = PW'(a_lat_q) * PW'(npts_pkg::Recip100);
  assign prod_lon = PW'(a_lon_q) * PW'(npts_pkg::Recip100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      a_lat_q  <= '0;
      a_lon_q  <= '0;
      n_lat_q  <= 1'b0;
      n_lon_q  <= 1'b0;
      n2_lat_q <= 1'b0;
      n2_lon_q <= 1'b0;
      qy_q     <= '0;
      qx_q     <= '0;
      sum_q    <= '0;
    end else begin
      s1_tag_q <= tag_i;
      a_lat_q  <= mlat[CW-1:0];
      a_lon_q  <= mlon[CW-1:0];
      n_lat_q  <= dlat[CW];
      n_lon_q  <= dlon[CW];
      s2_tag_q <= s1_tag_q;
      qy_q     <= prod_lat[npts_pkg::RecipShift +: QW];
      qx_q     <= prod_lon[npts_pkg::RecipShift +: QW];
      n2_lat_q <= n_lat_q;
      n2_lon_q <= n_lon_q;
      sum_q    <= DW'(a_lat_q) + DW'(a_lon_q);
    end
  end

  // Quotients keep the sign of the difference; zero is never ahead.
  always_comb begin
    case (dir_i)
      npts_pkg::DIR_RIGHT: begin
        ahead     = qx_q;
        lateral   = qy_q;
        ahead_pos = !n2_lon_q && (qx_q != '0);
      end
      npts_pkg::DIR_LEFT: begin
        ahead     = qx_q;
        lateral   = qy_q;
        ahead_pos = n2_lon_q && (qx_q != '0);
      end
      npts_pkg::DIR_UP: begin
        ahead     = qy_q;
        lateral   = qx_q;
        ahead_pos = !n2_lat_q && (qy_q != '0);
      end
      default: begin
        ahead     = qy_q;
        lateral   = qx_q;
        ahead_pos = n2_lat_q && (qy_q != '0);
      end
    endcase
  end

  assign met_o.vld    = s2_tag_q.vld;
  assign met_o.last   = s2_tag_q.last;
  assign met_o.elig   = direct_i ? ahead_pos : 1'b1;
  assign met_o.metric = direct_i ? DW'({lateral, 2'b00}) + DW'(ahead) : sum_q;

endmodule

FILE: hw/rtl/nearest_point_table_search_core.sv
// Top level of the nearest point table search: command sequencer, APB
// register, best-entry tracker. Uses npts_pkg, npts_store and npts_metric.
`timescale 1ns / 1ps
// Clear and append: done_o pulses in the cycle after start and busy_o
// stays low. A nearest or directional query over a table of entry_count
// points holds busy_o high through the scan, drain and finish states and
// pulses done_o at the end; the table is read one entry per cycle through
// its single read port, and each entry goes through the shared distance
// unit (difference, divide by 100, rank) and a compare stage. A query on
// an empty table answers in the next cycle. done_o is high for exactly one cycle
// with res_o valid; the receiver must take it then, there is no stall.
module nearest_point_table_search_core #(
  parameter int unsigned MAX_ENTRIES = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  npts_pkg::req_t req_i,
  output logic           done_o,
  output npts_pkg::res_t res_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW   = npts_pkg::DistW;
  localparam int unsigned CW   = npts_pkg::CoordW;
  localparam int unsigned OW   = npts_pkg::IdxOutW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q, scan_q;
  logic [IdxW-1:0]  cmp_idx_q, best_idx_q;
  logic [DW-1:0]    best_q, thr_q;
  logic             hit_q, direct_q, done_q;
  logic [CW-1:0]    q_lat_q, q_lon_q;
  logic [1:0]       dir_q;
  npts_pkg::res_t   res_q;
  npts_pkg::tag_t   rd_tag_q;

  npts_pkg::point_t rd_pt, wr_pt;
  npts_pkg::met_t   met;
  logic             room, mem_we, scan_last, found, thr_sel;
  logic [IdxW+OW-1:0] idx_ext;

  assign room      = count_q < CntW'(MAX_ENTRIES);
  assign mem_we    = (state_q == ST_IDLE) && start_i &&
                     (req_i.cmd == npts_pkg::CMD_APPEND) && room;
  assign wr_pt     = '{lat: req_i.coord_lat, lon: req_i.coord_lon};
  assign scan_last = CntW'(scan_q + CntW'(1)) == count_q;

  npts_store #(
    .Depth (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_pt),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_pt)
  );

  npts_metric u_metric (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .pt_i     (rd_pt),
    .q_lat_i  (q_lat_q),
    .q_lon_i  (q_lon_q),
    .dir_i    (dir_q),
    .direct_i (direct_q),
    .met_o    (met)
  );

  // Nearest query hits only within the threshold; best never exceeds 2^22-2.
  assign found   = hit_q && (direct_q || (best_q <= thr_q));
  assign idx_ext = {{OW{1'b0}}, best_idx_q};

  assign thr_sel = (paddr == npts_pkg::ThrAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= npts_pkg::ThrReset;
    end else if (psel && penable && pwrite && thr_sel) begin
      thr_q <= pwdata[DW-1:0];
    end
  end

  assign prdata = thr_sel ? {{(32-DW){1'b0}}, thr_q} : '0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      scan_q     <= '0;
      cmp_idx_q  <= '0;
      best_idx_q <= '0;
      best_q     <= '0;
      hit_q      <= 1'b0;
      direct_q   <= 1'b0;
      q_lat_q    <= '0;
      q_lon_q    <= '0;
      dir_q      <= '0;
      res_q      <= '0;
      done_q     <= 1'b0;
      rd_tag_q   <= '0;
    end else begin
      done_q   <= 1'b0;
      rd_tag_q <= '0;

      // Track the first least metric among eligible entries.
      if (met.vld) begin
        cmp_idx_q <= IdxW'(cmp_idx_q + IdxW'(1));
        if (met.elig && (!hit_q || (met.metric < best_q))) begin
          hit_q      <= 1'b1;
          best_q     <= met.metric;
          best_idx_q <= cmp_idx_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            case (req_i.cmd)
              npts_pkg::CMD_CLEAR: begin
                count_q <= '0;
                res_q   <= '0;
                done_q  <= 1'b1;
              end
              npts_pkg::CMD_APPEND: begin
                res_q <= '0;
                if (room) begin
                  count_q <= CntW'(count_q + CntW'(1));
                end else begin
                  res_q.table_full <= 1'b1;
                end
                done_q <= 1'b1;
              end
              default: begin
                q_lat_q   <= req_i.coord_lat;
                q_lon_q   <= req_i.coord_lon;
                dir_q     <= req_i.direction;
                direct_q  <= (req_i.cmd == npts_pkg::CMD_DIRECT);
                hit_q     <= 1'b0;
                scan_q    <= '0;
                cmp_idx_q <= '0;
                if (count_q == '0) begin
                  res_q  <= '0;
                  done_q <= 1'b1;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_tag_q <= '{vld: 1'b1, last: scan_last};
          scan_q   <= CntW'(scan_q + CntW'(1));
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (met.vld && met.last) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_q.found         <= found;
          res_q.entry_index   <= found ? idx_ext[OW-1:0] : '0;
          res_q.best_distance <= found ? best_q : '0;
          res_q.table_full    <= 1'b0;
          done_q              <= 1'b1;
          state_q             <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_fin_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (done_o && !busy_o))
    else $error("query finish did not report a result");

  a_busy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (count_q != '0))
    else $error("scan running over an empty table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_full_vs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.found && res_o.table_full))
    else $error("result flags both a hit and a dropped append");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_q < count_q))
    else $error("scan address past the last stored entry");

endmodule

FILE: dv/tb.sv
// Testbench for nearest_point_table_search_core: clear, append and query requests
// plus APB threshold writes, each result checked against a local model of the table.
// Depends on npts_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned TableDepth = 512;
  localparam int unsigned DistW = npts_pkg::DistW;
  localparam int unsigned CoordW = npts_pkg::CoordW;
  localparam int unsigned IdxOutW = npts_pkg::IdxOutW;
  localparam logic [1:0] ThrAddr = npts_pkg::ThrAddr;
  localparam logic [DistW-1:0] ThrReset = npts_pkg::ThrReset;
  localparam longint DistMax = 4194303;
  localparam longint CoordMin = -1048576;
  localparam longint CoordMax = 1048575;
  localparam longint DirScale = 100;
  localparam logic [DistW-1:0] ThrMax = 22'h3FFFFF;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct {
    npts_pkg::req_t rq;
    bit             hold;
  } pending_t;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  npts_pkg::req_t req_i   = '0;
  logic           psel    = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite  = 1'b0;
  logic [1:0]     paddr   = '0;
  logic [31:0]    pwdata  = '0;
  logic           busy_o;
  logic           done_o;
  npts_pkg::res_t res_o;
  logic [31:0]    prdata;
  logic           pready;

  nearest_point_table_search_core #(.MAX_ENTRIES(TableDepth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk_i = ~clk_i;

  pending_t       cmd_backlog[$];
  npts_pkg::res_t answers_due[$];
  int             fail_count = 0;
  int             gap_pct = 0;
  int             gen_count = 0;

  // model state: point table and threshold shadow
  logic [DistW-1:0]    thr_now = ThrReset;
  logic signed [CoordW-1:0] lat_tab[TableDepth];
  logic signed [CoordW-1:0] lon_tab[TableDepth];
  int unsigned         tab_count = 0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Apply one request to the model table and return the answer it must produce.
  function automatic npts_pkg::res_t search_outcome(npts_pkg::req_t rq);
    npts_pkg::res_t ans;
    longint      qlat, qlon, d, best, dy, dx, ahead, lateral;
    bit          hit;
    int unsigned pick;
    ans  = '0;
    hit  = 1'b0;
    best = 0;
    pick = 0;
    qlat = $signed(rq.coord_lat);
    qlon = $signed(rq.coord_lon);
    case (npts_pkg::cmd_e'(rq.cmd))
      npts_pkg::CMD_CLEAR: tab_count = 0;
      npts_pkg::CMD_APPEND: begin
        if (tab_count < TableDepth) begin
          lat_tab[tab_count] = rq.coord_lat;
          lon_tab[tab_count] = rq.coord_lon;
          tab_count++;
        end else begin
          ans.table_full = 1'b1;
        end
      end
      npts_pkg::CMD_NEAREST: begin
        for (int unsigned i = 0; i < tab_count; i++) begin
          d = mag(qlat - lat_tab[i]) + mag(qlon - lon_tab[i]);
          if (!hit || d < best) begin
            hit  = 1'b1;
            best = d;
            pick = i;
          end
        end
        if (hit && best > longint'(thr_now)) hit = 1'b0;
      end
      default: begin
        // directional query
        for (int unsigned i = 0; i < tab_count; i++) begin
          dy = (lat_tab[i] - qlat) / DirScale;
          dx = (lon_tab[i] - qlon) / DirScale;
          ahead   = 0;
          lateral = 0;
          case (npts_pkg::dir_e'(rq.direction))
            npts_pkg::DIR_RIGHT: begin
              ahead   = dx;
              lateral = dy;
            end
            npts_pkg::DIR_LEFT: begin
              ahead   = -dx;
              lateral = dy;
            end
            npts_pkg::DIR_UP: begin
              ahead   = dy;
              lateral = dx;
            end
            default: begin
              ahead   = -dy;
              lateral = dx;
            end
          endcase
          if (ahead > 0) begin
            d = 4 * mag(lateral) + ahead;
            if (!hit || d < best) begin
              hit  = 1'b1;
              best = d;
              pick = i;
            end
          end
        end
      end
    endcase
    if (hit) begin
      ans.found         = 1'b1;
      ans.entry_index   = pick[IdxOutW-1:0];
      ans.best_distance = (best > DistMax) ? ThrMax : best[DistW-1:0];
    end
    return ans;
  endfunction

  task automatic check_field(string fname, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", fname, exp, act);
      fail_count++;
    end
  endtask

  // Request driver: hold start until accepted, then launch the next request or idle.
  always @(posedge clk_i) begin
    bit launch;
    launch = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) answers_due.push_back(search_outcome(req_i));
      if (!(start_i && busy_o)) begin
        launch = cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct
                 && (!cmd_backlog[0].hold || answers_due.size() == 0);
        if (launch) begin
          req_i <= cmd_backlog[0].rq;
          void'(cmd_backlog.pop_front());
        end
        start_i <= launch;
      end
    end
  end

  // Result monitor: done_o marks a one-cycle result, compare with the oldest answer.
  always @(posedge clk_i) begin
    npts_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding: %h", res_o);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        check_field("found", want.found, res_o.found);
        check_field("entry_index", want.entry_index, res_o.entry_index);
        check_field("best_distance", want.best_distance, res_o.best_distance);
        check_field("table_full", want.table_full, res_o.table_full);
      end
    end
  end

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ThrAddr) thr_now = data[DistW-1:0];
  endtask

  task automatic apb_read(logic [1:0] addr, output logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(logic [DistW-1:0] v);
    logic [31:0] rd;
    apb_write(ThrAddr, 32'(v));
    apb_read(ThrAddr, rd);
    check_field("near_threshold", 32'(v), rd);
  endtask

  task automatic queue_cmd(npts_pkg::cmd_e c, coord_t lat, coord_t lon, npts_pkg::dir_e d,
                           bit hold = 1'b0);
    pending_t p;
    p.rq.cmd       = c;
    p.rq.coord_lat = lat;
    p.rq.coord_lon = lon;
    p.rq.direction = d;
    p.hold         = hold;
    cmd_backlog.push_back(p);
    if (c == npts_pkg::CMD_CLEAR) gen_count = 0;
    else if (c == npts_pkg::CMD_APPEND && gen_count < TableDepth) gen_count++;
  endtask

  function automatic coord_t near_coord(longint center, longint spread);
    longint v;
    v = center + longint'($urandom_range(2 * spread)) - spread;
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return v[CoordW-1:0];
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic npts_pkg::dir_e any_dir();
    return npts_pkg::dir_e'($urandom_range(3));
  endfunction

  // Wait for the backlog to drain and every answer to arrive, then idle for tail cycles.
  // Sample at the falling edge so a request launched at the last rising edge is seen.
  task automatic settle(int tail);
    int waited;
    waited = 0;
    while (cmd_backlog.size() != 0 || start_i) @(negedge clk_i);
    while (answers_due.size() != 0 && waited < 4 * TableDepth) begin
      @(negedge clk_i);
      waited++;
    end
    if (answers_due.size() != 0) begin
      $error("%0d results never arrived", answers_due.size());
      fail_count++;
      answers_due.delete();
    end
    repeat (tail) @(posedge clk_i);
  endtask

  // Fill the table to capacity, push past it, then query the full table.
  task automatic fill_table();
    longint clat, clon;
    coord_t flat, flon;
    clat = $signed(any_coord());
    clon = $signed(any_coord());
    queue_cmd(npts_pkg::CMD_CLEAR, any_coord(), any_coord(), any_dir(), 1'b1);
    repeat (TableDepth) begin
      flat = near_coord(clat, 30000);
      flon = near_coord(clon, 30000);
      queue_cmd(npts_pkg::CMD_APPEND, flat, flon, any_dir());
    end
    repeat (3) queue_cmd(npts_pkg::CMD_APPEND, any_coord(), any_coord(), any_dir());
    queue_cmd(npts_pkg::CMD_NEAREST, flat, flon, any_dir());
    queue_cmd(npts_pkg::CMD_NEAREST, near_coord(clat, 30000), near_coord(clon, 30000),
              any_dir());
    queue_cmd(npts_pkg::CMD_DIRECT, flat, flon, any_dir());
    queue_cmd(npts_pkg::CMD_DIRECT, near_coord(clat, 30000), near_coord(clon, 30000),
              any_dir());
  endtask

  // Mostly well-formed sequences: clear, a cluster of appends, queries near the cluster.
  task automatic random_phase(int n_items);
    int     target, n_app, k;
    longint clat, clon, spread;
    coord_t plat[$], plon[$];
    coord_t qlat, qlon;
    bit     hold;
    target = cmd_backlog.size() + n_items;
    while (cmd_backlog.size() < target) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 4))
          queue_cmd(npts_pkg::cmd_e'($urandom_range(3)), any_coord(), any_coord(), any_dir());
      end else begin
        hold = ($urandom_range(7) == 0);
        case ($urandom_range(3))
          0: spread = 100;
          1: spread = 1000;
          2: spread = 30000;
          default: spread = 500000;
        endcase
        clat = $signed(any_coord());
        clon = $signed(any_coord());
        if ($urandom_range(19) != 0 || gen_count > 48) begin
          queue_cmd(npts_pkg::CMD_CLEAR, any_coord(), any_coord(), any_dir(), hold);
          hold = 1'b0;
        end
        plat.delete();
        plon.delete();
        n_app = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(4, 24);
        repeat (n_app) begin
          plat.push_back(near_coord(clat, spread));
          plon.push_back(near_coord(clon, spread));
          queue_cmd(npts_pkg::CMD_APPEND, plat[$], plon[$], any_dir(), hold);
          hold = 1'b0;
        end
        repeat ($urandom_range(1, 6)) begin
          if (plat.size() != 0 && $urandom_range(2) == 0) begin
            k    = $urandom_range(plat.size() - 1);
            qlat = plat[k];
            qlon = plon[k];
          end else begin
            qlat = near_coord(clat, spread);
            qlon = near_coord(clon, spread);
          end
          queue_cmd($urandom_range(1) ? npts_pkg::CMD_NEAREST : npts_pkg::CMD_DIRECT,
                    qlat, qlon, any_dir(), hold);
          hold = 1'b0;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] rd;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_read(ThrAddr, rd);
    check_field("near_threshold", 32'(ThrReset), rd);
    gap_pct = 8;

    // empty table, extreme points, duplicates, truncation of the divide by 100
    queue_cmd(npts_pkg::CMD_NEAREST, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_DIRECT, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_CLEAR, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_APPEND, -21'sd1048576, -21'sd1048576, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_APPEND, 21'sd1048575, 21'sd1048575, npts_pkg::DIR_DOWN);
    queue_cmd(npts_pkg::CMD_APPEND, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_APPEND, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_APPEND, 21'sd150, -21'sd99, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_NEAREST, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_NEAREST, 21'sd1048575, 21'sd1048575, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_NEAREST, -21'sd1048576, 21'sd1048575, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_DIRECT, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_DIRECT, 21'sd0, 21'sd0, npts_pkg::DIR_LEFT);
    queue_cmd(npts_pkg::CMD_DIRECT, 21'sd0, -21'sd99, npts_pkg::DIR_UP);
    queue_cmd(npts_pkg::CMD_DIRECT, 21'sd199, 21'sd0, npts_pkg::DIR_DOWN);
    settle(2);

    // zero threshold: only an exact match hits
    set_threshold('0);
    queue_cmd(npts_pkg::CMD_NEAREST, 21'sd150, -21'sd99, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_NEAREST, 21'sd151, -21'sd99, npts_pkg::DIR_RIGHT);
    settle(2);

    // widest threshold: corner-to-corner distance still hits
    set_threshold(ThrMax);
    queue_cmd(npts_pkg::CMD_NEAREST, -21'sd1048576, 21'sd1048575, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_CLEAR, 21'sd0, 21'sd0, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_APPEND, 21'sd1048575, 21'sd1048575, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_NEAREST, -21'sd1048576, -21'sd1048576, npts_pkg::DIR_RIGHT);
    queue_cmd(npts_pkg::CMD_DIRECT, -21'sd1048576, -21'sd1048576, npts_pkg::DIR_UP);
    settle(2);

    set_threshold(DistW'($urandom_range(200000)));
    random_phase(210);
    settle(2);

    gap_pct = 53;
    set_threshold(ThrMax);
    fill_table();
    random_phase(210);
    settle(2);

    gap_pct = 0;
    set_threshold(DistW'($urandom_range(4194303)));
    random_phase(210);
    settle(TableDepth + 8);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: nearest_point_table_search_core.f
hw/rtl/npts_pkg.sv
hw/rtl/npts_store.sv
hw/rtl/npts_metric.sv
hw/rtl/nearest_point_table_search_core.sv
dv/tb.sv
